>>> design/xedt_pkg.sv
// shared types, constants and entity table for the xml entity decoder with trimming
`default_nettype none
package xedt_pkg;

	// whitespace hold store
	localparam int WS_HOLD_DEPTH = 32;
	localparam int HOLD_AW = $clog2(WS_HOLD_DEPTH);
	localparam int CNT_W = $clog2(WS_HOLD_DEPTH + 1);

	// named entity table, bytes stored low byte first
	localparam int ENT_NUM = 5;
	localparam int ENT_MAXLEN = 5;
	localparam int ENT_BUF_BYTES = 4;

	typedef logic [7:0] byte_t;
	typedef logic [8*ENT_MAXLEN-1:0] ent_name_t;

	localparam ent_name_t ENT_NAME [ENT_NUM] = '{
		40'h00_003B_746C,	// lt;
		40'h00_003B_7467,	// gt;
		40'h00_3B70_6D61,	// amp;
		40'h3B_746F_7571,	// quot;
		40'h3B_736F_7061	// apos;
	};
	localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
	localparam byte_t ENT_CHAR [ENT_NUM] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

	// character codes
	localparam byte_t CH_AMP = 8'h26;
	localparam byte_t CH_HASH = 8'h23;
	localparam byte_t CH_SEMI = 8'h3B;
	localparam byte_t CH_ZERO = 8'h30;
	localparam byte_t CH_NINE = 8'h39;
	localparam byte_t CH_SPACE = 8'h20;
	localparam byte_t CH_TAB = 8'h09;
	localparam byte_t CH_CR = 8'h0D;
	localparam byte_t CH_LF = 8'h0A;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_ENTITY = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	// request payloads
	typedef struct packed {
		byte_t in_byte;
		logic in_last;
	} in_t;

	typedef struct packed {
		byte_t out_byte;
		logic out_valid;
		logic out_last;
		logic [1:0] error_code;
	} out_t;

	// decoder mode
	typedef enum logic [2:0] {
		MODE_PLAIN,
		MODE_AMP,
		MODE_NAMED,
		MODE_HASH,
		MODE_DIGITS
	} mode_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_DLV,
		S_REL,
		S_FIN,
		S_END
	} ctl_state_t;

	// what decoding the current byte asks for
	typedef enum logic [1:0] {
		DK_NONE,
		DK_DLV,
		DK_FAIL
	} dec_kind_t;

	// what closing the value asks for
	typedef enum logic [1:0] {
		FK_NONE,
		FK_DLV,
		FK_FAIL
	} fin_kind_t;

	// output register source
	typedef enum logic [1:0] {
		EM_NONE,
		EM_PEND,
		EM_HELD,
		EM_END
	} emit_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic dec_commit;
		logic fail_start;
		logic fail_next;
		logic fail_end;
		logic fin_load;
		logic hold;
		emit_t emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		dec_kind_t dec_kind;
		logic dec_refeed;
		fin_kind_t fin_kind;
		logic last;
		logic pend_ws;
		logic started;
		logic count_zero;
		logic count_full;
		logic rel_last;
		logic fail_done;
		logic slot_free;
	} st_t;

endpackage
`default_nettype wire

>>> design/xml_entity_decode_trim_core.sv
// top level of the xml entity decoder with whitespace trimming
//
//   channel  signals                          payload
//   in       in_valid / in_ready / in_data    in_byte, in_last
//   out      out_valid / out_ready / out_data out_byte, out_valid, out_last, error_code
//
// a plain byte is accepted, decoded and delivered; a byte absorbed into an entity or
// number is accepted and decoded only; a byte other than ';' ending a number, or one
// failing an entity, is decoded again after its delivery or the bytes given back.
// held whitespace is released one byte per cycle from the hold ram while the output
// register is free, once the controller has switched over to the release.
// the last byte adds a close check and an end marker, plus any pending
// entity close.
// arst_n clears all control state; the hold ram is not cleared and needs no pass.
// a full output register with out_ready low stalls every cycle that writes it; input waits.
`default_nettype none
module xml_entity_decode_trim_core import xedt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_t out_data
);

	cmd_t cmd;
	st_t st;

	// controller
	xedt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.st(st)
	);

	// datapath
	xedt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.out_ready(out_ready),
		.out_data(out_data),
		.out_valid(out_valid),
		.cmd(cmd),
		.st(st)
	);

	// hold store never written past its depth
	a_hold_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hold |-> !st.count_full)
		else $error("whitespace written into a full hold store");

	// end marker carries no byte and no error
	a_end_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.out_valid) |-> (out_data.out_last &&
		out_data.error_code == ERR_NONE))
		else $error("malformed end marker");

	// end of value leaves a fresh decoder behind
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EM_END) |=> (!st.started && st.count_zero))
		else $error("value state not cleared after end marker");

	// results are only written into a free output register
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EM_NONE) |-> (!out_valid || out_ready))
		else $error("output register overwritten");

endmodule
`default_nettype wire

>>> design/xedt_ram.sv
// generic single write port ram with registered read
`default_nettype none
module xedt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> design/xedt_dp.sv
// datapath: byte decode, entity and number registers, hold store and output register
`default_nettype none
module xedt_dp import xedt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire in_t in_data,
	input wire logic out_ready,
	output out_t out_data,
	output logic out_valid,
	input wire cmd_t cmd,
	output st_t st
);

	byte_t cur_q;
	logic last_q;
	mode_t mode_q;
	logic [8*ENT_BUF_BYTES-1:0] ent_chars_q;
	logic [2:0] ent_len_q;
	byte_t num_q;
	logic started_q;
	logic [CNT_W-1:0] cnt_q;
	logic [HOLD_AW-1:0] rd_idx_q;
	byte_t pend_ch_q;
	logic [1:0] pend_err_q;
	logic [2:0] fidx_q;
	out_t out_q;
	logic out_vld_q;

	// decode results
	dec_kind_t dk;
	logic drefeed;
	mode_t mode_d;
	logic [8*ENT_BUF_BYTES-1:0] ent_chars_d;
	logic [2:0] ent_len_d;
	byte_t num_d;
	byte_t dch;
	logic [1:0] derr;
	logic full_hit;
	logic part_hit;
	byte_t full_ch;
	logic digit;
	byte_t dval;
	byte_t num_x10;
	fin_kind_t fk;

	// hold store
	logic [HOLD_AW-1:0] raddr;
	byte_t ram_rdata;
	logic rel_last;
	logic [1:0] rel_err;
	logic count_full;
	logic slot_free;

	function automatic logic is_ws(input byte_t c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	assign digit = cur_q >= CH_ZERO && cur_q <= CH_NINE;
	assign dval = cur_q - CH_ZERO;
	assign num_x10 = 8'({num_q, 3'b000} + {num_q, 1'b0}) + dval;

	// match buffered entity bytes plus current byte against the name table
	always_comb begin
		logic eq;
		logic [3:0] n;
		byte_t bufc [ENT_MAXLEN];
		n = {1'b0, ent_len_q} + 4'd1;
		for (int k = 0; k < ENT_BUF_BYTES; k++) begin
			bufc[k] = (4'(k) < {1'b0, ent_len_q}) ? ent_chars_q[8*k +: 8] : cur_q;
		end
		bufc[ENT_MAXLEN-1] = cur_q;
		full_hit = 1'b0;
		part_hit = 1'b0;
		full_ch = '0;
		for (int i = 0; i < ENT_NUM; i++) begin
			eq = 1'b1;
			for (int k = 0; k < ENT_MAXLEN; k++) begin
				if (4'(k) < n && bufc[k] != ENT_NAME[i][8*k +: 8]) begin
					eq = 1'b0;
				end
			end
			if (eq && n == {1'b0, ENT_LEN[i]}) begin
				full_hit = 1'b1;
				full_ch = ENT_CHAR[i];
			end
			if (eq && n < {1'b0, ENT_LEN[i]}) begin
				part_hit = 1'b1;
			end
		end
	end

	// next decoder state for the current byte
	always_comb begin
		dk = DK_NONE;
		drefeed = 1'b0;
		mode_d = mode_q;
		ent_chars_d = ent_chars_q;
		ent_len_d = ent_len_q;
		num_d = num_q;
		dch = cur_q;
		derr = ERR_NONE;
		case (mode_q)
			MODE_AMP, MODE_NAMED: begin
				if (mode_q == MODE_AMP && cur_q == CH_HASH) begin
					mode_d = MODE_HASH;
					num_d = '0;
				end else if (full_hit) begin
					dk = DK_DLV;
					dch = full_ch;
					mode_d = MODE_PLAIN;
					ent_chars_d = '0;
					ent_len_d = '0;
				end else if (part_hit) begin
					ent_chars_d[8*ent_len_q[1:0] +: 8] = cur_q;
					ent_len_d = ent_len_q + 3'd1;
					mode_d = MODE_NAMED;
				end else begin
					dk = DK_FAIL;
					drefeed = 1'b1;
				end
			end
			MODE_HASH: begin
				if (digit) begin
					num_d = dval;
					mode_d = MODE_DIGITS;
				end else begin
					dk = DK_DLV;
					dch = '0;
					derr = ERR_ENTITY;
					mode_d = MODE_PLAIN;
					drefeed = cur_q != CH_SEMI;
				end
			end
			MODE_DIGITS: begin
				if (digit) begin
					num_d = num_x10;
				end else begin
					dk = DK_DLV;
					dch = num_q;
					mode_d = MODE_PLAIN;
					drefeed = cur_q != CH_SEMI;
				end
			end
			default: begin
				mode_d = MODE_PLAIN;
				if (cur_q == CH_AMP) begin
					mode_d = MODE_AMP;
					ent_chars_d = '0;
					ent_len_d = '0;
				end else begin
					dk = DK_DLV;
				end
			end
		endcase
	end

	// closing action at end of value
	always_comb begin
		case (mode_q)
			MODE_AMP, MODE_NAMED: fk = FK_FAIL;
			MODE_HASH, MODE_DIGITS: fk = FK_DLV;
			default: fk = FK_NONE;
		endcase
	end

	// hold store release bookkeeping; whitespace pending means an overflow release
	assign count_full = cnt_q == CNT_W'(WS_HOLD_DEPTH);
	assign rel_last = (CNT_W'(rd_idx_q) + CNT_W'(1)) == cnt_q;
	assign rel_err = is_ws(pend_ch_q) ? ERR_OVERFLOW : ERR_NONE;
	assign slot_free = !out_vld_q || out_ready;

	always_comb begin
		if (cmd.emit == EM_HELD) begin
			raddr = rel_last ? '0 : rd_idx_q + HOLD_AW'(1);
		end else begin
			raddr = rd_idx_q;
		end
	end

	xedt_ram #(
		.WIDTH($bits(byte_t)),
		.DEPTH(WS_HOLD_DEPTH)
	) u_hold (
		.clk(clk),
		.we(cmd.hold),
		.waddr(cnt_q[HOLD_AW-1:0]),
		.wdata(pend_ch_q),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			ent_chars_q <= '0;
			ent_len_q <= '0;
			num_q <= '0;
			started_q <= 1'b0;
			cnt_q <= '0;
			rd_idx_q <= '0;
			fidx_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.dec_commit) begin
				mode_q <= mode_d;
				ent_chars_q <= ent_chars_d;
				ent_len_q <= ent_len_d;
				num_q <= num_d;
			end
			if (cmd.fail_end) begin
				mode_q <= MODE_PLAIN;
				ent_chars_q <= '0;
				ent_len_q <= '0;
			end
			if (cmd.fail_start) begin
				fidx_q <= '0;
			end else if (cmd.fail_next) begin
				fidx_q <= fidx_q + 3'd1;
			end
			if (cmd.hold) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			case (cmd.emit)
				EM_PEND: begin
					started_q <= 1'b1;
				end
				EM_HELD: begin
					if (rel_last) begin
						cnt_q <= '0;
						rd_idx_q <= '0;
					end else begin
						rd_idx_q <= rd_idx_q + HOLD_AW'(1);
					end
				end
				EM_END: begin
					mode_q <= MODE_PLAIN;
					ent_chars_q <= '0;
					ent_len_q <= '0;
					num_q <= '0;
					started_q <= 1'b0;
					cnt_q <= '0;
					rd_idx_q <= '0;
				end
				default: begin
				end
			endcase
			if (cmd.emit != EM_NONE) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q <= in_data.in_byte;
			last_q <= in_data.in_last;
		end
		if (cmd.dec_commit && dk == DK_DLV) begin
			pend_ch_q <= dch;
			pend_err_q <= derr;
		end else if (cmd.fail_start) begin
			pend_ch_q <= CH_AMP;
			pend_err_q <= ERR_ENTITY;
		end else if (cmd.fail_next) begin
			pend_ch_q <= ent_chars_q[8*fidx_q[1:0] +: 8];
			pend_err_q <= ERR_NONE;
		end else if (cmd.fin_load) begin
			if (mode_q == MODE_HASH) begin
				pend_ch_q <= '0;
				pend_err_q <= ERR_ENTITY;
			end else begin
				pend_ch_q <= num_q;
				pend_err_q <= ERR_NONE;
			end
		end
		case (cmd.emit)
			EM_PEND: out_q <= '{out_byte: pend_ch_q, out_valid: 1'b1, out_last: 1'b0,
				error_code: pend_err_q};
			EM_HELD: out_q <= '{out_byte: ram_rdata, out_valid: 1'b1, out_last: 1'b0,
				error_code: rel_err};
			EM_END: out_q <= '{out_byte: '0, out_valid: 1'b0, out_last: 1'b1,
				error_code: ERR_NONE};
			default: begin
			end
		endcase
	end

	// status back to the controller
	always_comb begin
		st.dec_kind = dk;
		st.dec_refeed = drefeed;
		st.fin_kind = fk;
		st.last = last_q;
		st.pend_ws = is_ws(pend_ch_q);
		st.started = started_q;
		st.count_zero = cnt_q == '0;
		st.count_full = count_full;
		st.rel_last = rel_last;
		st.fail_done = fidx_q == ent_len_q;
		st.slot_free = slot_free;
	end

	assign out_data = out_q;
	assign out_valid = out_vld_q;

endmodule
`default_nettype wire

>>> design/xedt_ctrl.sv
// controller state machine sequencing decode, delivery, release and end of value
`default_nettype none
module xedt_ctrl import xedt_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input wire st_t st
);

	ctl_state_t state_q, state_d;
	logic refeed_q, refeed_d;
	logic final_q, final_d;
	logic fail_q, fail_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			refeed_q <= 1'b0;
			final_q <= 1'b0;
			fail_q <= 1'b0;
		end else begin
			state_q <= state_d;
			refeed_q <= refeed_d;
			final_q <= final_d;
			fail_q <= fail_d;
		end
	end

	// next state and commands
	always_comb begin
		logic dlv_done;
		logic step_done;
		cmd = '0;
		cmd.emit = EM_NONE;
		state_d = state_q;
		refeed_d = refeed_q;
		final_d = final_q;
		fail_d = fail_q;
		dlv_done = 1'b0;
		step_done = 1'b0;
		in_ready = state_q == S_IDLE;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				refeed_d = st.dec_refeed;
				case (st.dec_kind)
					DK_DLV: begin
						cmd.dec_commit = 1'b1;
						state_d = S_DLV;
					end
					DK_FAIL: begin
						cmd.fail_start = 1'b1;
						fail_d = 1'b1;
						state_d = S_DLV;
					end
					default: begin
						cmd.dec_commit = 1'b1;
						step_done = 1'b1;
					end
				endcase
			end
			S_DLV: begin
				if (!st.started) begin
					// leading whitespace is dropped
					if (st.pend_ws) begin
						dlv_done = 1'b1;
					end else if (st.slot_free) begin
						cmd.emit = EM_PEND;
						dlv_done = 1'b1;
					end
				end else if (st.pend_ws) begin
					if (st.count_full) begin
						state_d = S_REL;
					end else begin
						cmd.hold = 1'b1;
						dlv_done = 1'b1;
					end
				end else if (!st.count_zero) begin
					state_d = S_REL;
				end else if (st.slot_free) begin
					cmd.emit = EM_PEND;
					dlv_done = 1'b1;
				end
			end
			S_REL: begin
				if (st.slot_free) begin
					cmd.emit = EM_HELD;
					if (st.rel_last) begin
						state_d = S_DLV;
					end
				end
			end
			S_FIN: begin
				final_d = 1'b1;
				case (st.fin_kind)
					FK_FAIL: begin
						cmd.fail_start = 1'b1;
						fail_d = 1'b1;
						state_d = S_DLV;
					end
					FK_DLV: begin
						cmd.fin_load = 1'b1;
						state_d = S_DLV;
					end
					default: begin
						state_d = S_END;
					end
				endcase
			end
			S_END: begin
				if (st.slot_free) begin
					cmd.emit = EM_END;
					final_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// failed entity: walk '&' then the buffered bytes
		if (dlv_done) begin
			if (fail_q && !st.fail_done) begin
				cmd.fail_next = 1'b1;
				state_d = S_DLV;
			end else begin
				if (fail_q) begin
					cmd.fail_end = 1'b1;
					fail_d = 1'b0;
				end
				step_done = 1'b1;
			end
		end

		// byte finished: decode again, close the value or wait for the next byte
		if (step_done) begin
			if (refeed_d) begin
				refeed_d = 1'b0;
				state_d = S_DEC;
			end else if (st.last && !final_q) begin
				state_d = S_FIN;
			end else if (st.last) begin
				state_d = S_END;
			end else begin
				state_d = S_IDLE;
			end
		end
	end

endmodule
`default_nettype wire

>>> verif/xml_entity_decode_trim_core_tb.sv
// self-checking testbench for the xml entity decoder with whitespace trimming
module xml_entity_decode_trim_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import xedt_pkg::*;

	localparam int MATCH_PARTIAL = ENT_NUM;
	localparam int MATCH_NONE = ENT_NUM + 1;
	localparam int RANDOM_ITEMS = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam byte_t CH_MINUS = 8'h2D;
	localparam byte_t CH_PLUS = 8'h2B;
	localparam byte_t SPACE_CODES [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
	localparam int SEND_IDLE [4] = '{0, 61, 0, 9};
	localparam int RECV_STALL [4] = '{0, 0, 61, 9};

	// decoder state mirror and queue of expected decoded characters
	class decoded_text_board;
		out_t expected_out[$];
		int mismatches = 0;
		mode_t mode = MODE_PLAIN;
		logic [39:0] ent_buf = '0;
		int ent_len = 0;
		byte_t num_val = '0;
		bit started = 1'b0;
		byte_t held[WS_HOLD_DEPTH];
		int held_n = 0;

		function int pending();
			return expected_out.size();
		endfunction

		function bit is_space(byte_t c);
			return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
		endfunction

		function void push_out(byte_t b, logic v, logic l, logic [1:0] err);
			out_t o;
			o.out_byte = b;
			o.out_valid = v;
			o.out_last = l;
			o.error_code = err;
			expected_out.push_back(o);
		endfunction

		function void release_held(logic [1:0] err);
			for (int k = 0; k < held_n; k++)
				push_out(held[k], 1'b1, 1'b0, err);
			held_n = 0;
		endfunction

		// leading whitespace dropped, inner whitespace held until content follows
		function void put_char(byte_t c, logic [1:0] err);
			if (!started) begin
				if (is_space(c))
					return;
				started = 1'b1;
				push_out(c, 1'b1, 1'b0, err);
			end else if (is_space(c)) begin
				if (held_n >= WS_HOLD_DEPTH)
					release_held(ERR_OVERFLOW);
				held[held_n] = c;
				held_n++;
			end else begin
				release_held(ERR_NONE);
				push_out(c, 1'b1, 1'b0, err);
			end
		endfunction

		function void clear_entity();
			mode = MODE_PLAIN;
			ent_len = 0;
			ent_buf = '0;
		endfunction

		// full match index, or partial, or none
		function int match_entity(byte_t b);
			int n;
			bit partial;
			bit same;
			byte_t have;
			n = ent_len + 1;
			partial = 1'b0;
			if (n > ENT_MAXLEN)
				return MATCH_NONE;
			for (int i = 0; i < ENT_NUM; i++) begin
				if (n <= ENT_LEN[i]) begin
					same = 1'b1;
					for (int k = 0; k < n; k++) begin
						have = (k == n - 1) ? b : ent_buf[8*k +: 8];
						if (have != ENT_NAME[i][8*k +: 8])
							same = 1'b0;
					end
					if (same) begin
						if (n == ENT_LEN[i])
							return i;
						partial = 1'b1;
					end
				end
			end
			return partial ? MATCH_PARTIAL : MATCH_NONE;
		endfunction

		// unknown entity: ampersand flagged, collected bytes passed on as text
		function void give_back_entity();
			put_char(CH_AMP, ERR_ENTITY);
			for (int k = 0; k < ent_len; k++)
				put_char(ent_buf[8*k +: 8], ERR_NONE);
			clear_entity();
		endfunction

		function void decode_byte(byte_t b);
			bit again;
			bit digit;
			int hit;
			digit = (b >= CH_ZERO) && (b <= CH_NINE);
			again = 1'b1;
			while (again) begin
				again = 1'b0;
				case (mode)
					MODE_AMP, MODE_NAMED: begin
						if (mode == MODE_AMP && b == CH_HASH) begin
							mode = MODE_HASH;
							num_val = '0;
						end else begin
							hit = match_entity(b);
							if (hit < MATCH_PARTIAL) begin
								put_char(ENT_CHAR[hit], ERR_NONE);
								clear_entity();
							end else if (hit == MATCH_PARTIAL) begin
								ent_buf[8*ent_len +: 8] = b;
								ent_len++;
								mode = MODE_NAMED;
							end else begin
								give_back_entity();
								again = 1'b1;
							end
						end
					end
					MODE_HASH: begin
						if (digit) begin
							num_val = b - CH_ZERO;
							mode = MODE_DIGITS;
						end else begin
							put_char(8'h00, ERR_ENTITY);
							mode = MODE_PLAIN;
							again = (b != CH_SEMI);
						end
					end
					MODE_DIGITS: begin
						if (digit) begin
							num_val = num_val * 8'd10 + (b - CH_ZERO);
						end else begin
							put_char(num_val, ERR_NONE);
							mode = MODE_PLAIN;
							again = (b != CH_SEMI);
						end
					end
					default: begin
						mode = MODE_PLAIN;
						if (b == CH_AMP) begin
							mode = MODE_AMP;
							ent_len = 0;
							ent_buf = '0;
						end else begin
							put_char(b, ERR_NONE);
						end
					end
				endcase
			end
		endfunction

		// accepted request: predict its decoded characters
		function void note_request(in_t item);
			decode_byte(item.in_byte);
			if (item.in_last) begin
				case (mode)
					MODE_AMP, MODE_NAMED: give_back_entity();
					MODE_HASH: put_char(8'h00, ERR_ENTITY);
					MODE_DIGITS: put_char(num_val, ERR_NONE);
					default: ;
				endcase
				held_n = 0;
				push_out(8'h00, 1'b0, 1'b1, ERR_NONE);
				clear_entity();
				num_val = '0;
				started = 1'b0;
			end
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s expected %0h got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		// accepted result against the oldest prediction
		function void check_result(out_t got);
			out_t want;
			if (expected_out.size() == 0) begin
				$error("unexpected result: out_byte %0h out_valid %0b out_last %0b error_code %0d",
					got.out_byte, got.out_valid, got.out_last, got.error_code);
				mismatches++;
				return;
			end
			want = expected_out.pop_front();
			check_field("out_byte", want.out_byte, got.out_byte);
			check_field("out_valid", want.out_valid, got.out_valid);
			check_field("out_last", want.out_last, got.out_last);
			check_field("error_code", want.error_code, got.error_code);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	decoded_text_board board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	xml_entity_decode_trim_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// handshake monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_request(in_data);
			if (out_valid && out_ready)
				board.check_result(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// one request, with a random idle gap before it
	task automatic send_byte(byte_t b, logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= '{in_byte: b, in_last: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(byte_t txt[$]);
		for (int i = 0; i < txt.size(); i++)
			send_byte(txt[i], i == txt.size() - 1);
	endtask

	// sender holds off until every predicted character has come back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic void append_text(ref byte_t txt[$], input string s);
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
	endfunction

	function automatic void append_space(ref byte_t txt[$], input int n);
		repeat (n)
			txt.push_back(SPACE_CODES[$urandom_range(3)]);
	endfunction

	// one value built from random well-formed and broken pieces
	function automatic void build_value(ref byte_t txt[$]);
		int segs;
		int kind;
		int idx;
		int len;
		int cut;
		txt.delete();
		if ($urandom_range(99) < 30)
			append_space(txt, $urandom_range(1, 3));
		segs = $urandom_range(1, 8);
		repeat (segs) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				txt.push_back(byte_t'($urandom_range(8'h21, 8'h7E)));
			end else if (kind < 30) begin
				append_space(txt, 1);
			end else if (kind < 33) begin
				// content then a run long enough to overflow the hold store
				txt.push_back(byte_t'($urandom_range(8'h41, 8'h5A)));
				append_space(txt, $urandom_range(WS_HOLD_DEPTH + 1, WS_HOLD_DEPTH + 8));
			end else if (kind < 55) begin
				idx = $urandom_range(ENT_NUM - 1);
				txt.push_back(CH_AMP);
				for (int k = 0; k < ENT_LEN[idx]; k++)
					txt.push_back(ENT_NAME[idx][8*k +: 8]);
			end else if (kind < 65) begin
				// named entity prefix broken by a random byte
				idx = $urandom_range(ENT_NUM - 1);
				len = $urandom_range(ENT_LEN[idx] - 1);
				txt.push_back(CH_AMP);
				for (int k = 0; k < len; k++)
					txt.push_back(ENT_NAME[idx][8*k +: 8]);
				txt.push_back(byte_t'($urandom()));
			end else if (kind < 80) begin
				append_text(txt, "&#");
				if ($urandom_range(4) == 0)
					append_text(txt, $sformatf("%0d", SPACE_CODES[$urandom_range(3)]));
				else
					append_text(txt, $sformatf("%0d", $urandom_range(0, 99999)));
				if ($urandom_range(1))
					txt.push_back(CH_SEMI);
			end else if (kind < 86) begin
				append_text(txt, "&#");
				case ($urandom_range(3))
					0: txt.push_back(CH_SEMI);
					1: txt.push_back(CH_MINUS);
					2: txt.push_back(CH_PLUS);
					default: txt.push_back(byte_t'($urandom()));
				endcase
			end else begin
				txt.push_back(byte_t'($urandom()));
			end
		end
		// sometimes end the value in the middle of a piece
		if ($urandom_range(9) == 0) begin
			cut = $urandom_range(1, txt.size());
			while (txt.size() > cut)
				void'(txt.pop_back());
		end
	endfunction

	// stimulus
	initial begin
		byte_t txt[$];
		board = new;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed values
		append_text(txt, "&#9; &lt;&#300 &#;&#-&ax &am");
		send_text(txt);
		txt = '{8'hFF, 8'h00, CH_SPACE};
		send_text(txt);
		wait_for_drain();

		// random values over the idling phases
		items_sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			while (items_sent < (ph + 1) * RANDOM_ITEMS / 4) begin
				build_value(txt);
				send_text(txt);
			end
			if (ph == 1)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
design/xedt_pkg.sv
design/xedt_ram.sv
design/xedt_dp.sv
design/xedt_ctrl.sv
design/xml_entity_decode_trim_core.sv
verif/xml_entity_decode_trim_core_tb.sv
